// ===== sv/gbc_pkg.sv =====
// Package for the GPIO bank controller: transaction types, command and register codes.
// Used by gbc_regs and gpio_bank_controller_unit; depends on nothing.
package gbc_pkg;

	// Fixed field widths of the transactions.
	localparam int FIELD_W = 54;
	localparam int DATA_W = 32;
	localparam int MAX_PINS = 64;
	localparam int NUM_PINS_DEF = 54;

	// Function select layout: three bits a pin, ten pins a word, six words.
	localparam int FSEL_W = 3;
	localparam int PINS_PER_FSEL = 10;
	localparam int FSEL_WORDS = 6;

	// Commands.
	localparam logic [1:0] CMD_READ = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Register indexes.
	localparam logic [4:0] REG_FSEL0 = 5'd0;
	localparam logic [4:0] REG_FSEL1 = 5'd1;
	localparam logic [4:0] REG_FSEL2 = 5'd2;
	localparam logic [4:0] REG_FSEL3 = 5'd3;
	localparam logic [4:0] REG_FSEL4 = 5'd4;
	localparam logic [4:0] REG_FSEL5 = 5'd5;
	localparam logic [4:0] REG_SET0 = 5'd6;
	localparam logic [4:0] REG_SET1 = 5'd7;
	localparam logic [4:0] REG_CLR0 = 5'd8;
	localparam logic [4:0] REG_CLR1 = 5'd9;
	localparam logic [4:0] REG_LEV0 = 5'd10;
	localparam logic [4:0] REG_LEV1 = 5'd11;
	localparam logic [4:0] REG_EDS0 = 5'd12;
	localparam logic [4:0] REG_EDS1 = 5'd13;
	localparam logic [4:0] REG_REN0 = 5'd14;
	localparam logic [4:0] REG_REN1 = 5'd15;
	localparam logic [4:0] REG_FEN0 = 5'd16;
	localparam logic [4:0] REG_FEN1 = 5'd17;
	localparam logic [4:0] REG_PUD = 5'd18;
	localparam logic [4:0] REG_PUDCLK0 = 5'd19;
	localparam logic [4:0] REG_PUDCLK1 = 5'd20;

	// Function and pull codes.
	localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;
	localparam logic [1:0] PULL_OFF = 2'd0;
	localparam logic [1:0] PULL_DOWN = 2'd1;
	localparam logic [1:0] PULL_UP = 2'd2;

	// Request transaction.
	typedef struct packed {
		logic [1:0] command;
		logic [4:0] reg_index;
		logic [DATA_W-1:0] write_data;
		logic [FIELD_W-1:0] pin_levels;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [FIELD_W-1:0] drive_level;
		logic [FIELD_W-1:0] output_enable;
		logic [FIELD_W-1:0] pull_up_enable;
		logic [FIELD_W-1:0] pull_down_enable;
		logic event_interrupt;
	} rsp_t;

	// Execute request from the input stage to the register bank.
	typedef struct packed {
		logic fire;
		req_t req;
	} exec_t;

endpackage

// ===== sv/gbc_regs.sv =====
// Register bank of the GPIO bank controller: pin state, update logic and read multiplexer.
// Depends on gbc_pkg; produces the response for the transaction that executes this cycle.
module gbc_regs #(
	parameter int NUM_PINS = gbc_pkg::NUM_PINS_DEF
) (
	input logic clk,
	input logic arst_n,
	input gbc_pkg::exec_t exec,
	output gbc_pkg::rsp_t result
);

	localparam int HI_W = NUM_PINS - 32;

	// Architectural state.
	logic [NUM_PINS-1:0] latch_q, level_q, event_q, ren_q, fen_q;
	logic [NUM_PINS-1:0] latch_d, level_d, event_d, ren_d, fen_d;
	logic [1:0] pud_q, pud_d;
	logic [gbc_pkg::FSEL_W-1:0] func_q [NUM_PINS];
	logic [gbc_pkg::FSEL_W-1:0] func_d [NUM_PINS];
	logic [1:0] pull_q [NUM_PINS];
	logic [1:0] pull_d [NUM_PINS];

	logic is_write;
	logic [4:0] idx;
	logic [gbc_pkg::DATA_W-1:0] wdata;
	logic [NUM_PINS-1:0] place0, place1, mask0, mask1, place_pair, mask_pair, pudclk_sel;
	logic [NUM_PINS-1:0] now, oe_vec, pu_vec, pd_vec;
	logic [gbc_pkg::MAX_PINS-1:0] level64, event64, ren64, fen64;
	logic [gbc_pkg::MAX_PINS-1:0] latch64_d, event64_d, oe64, pu64, pd64;
	logic [gbc_pkg::MAX_PINS-1:0] levels_in64;
	logic [gbc_pkg::DATA_W-1:0] fsel_word [gbc_pkg::FSEL_WORDS];
	logic [gbc_pkg::DATA_W-1:0] rd;

	assign is_write = exec.fire && (exec.req.command == gbc_pkg::CMD_WRITE);
	assign idx = exec.req.reg_index;
	assign wdata = exec.req.write_data;

	// Write data placed on the low or high word of the pin vector.
	assign place0 = {{HI_W{1'b0}}, wdata};
	assign place1 = {wdata[HI_W-1:0], 32'd0};
	assign mask0 = {{HI_W{1'b0}}, {32{1'b1}}};
	assign mask1 = {{HI_W{1'b1}}, 32'd0};
	// Register pairs from set to falling enable start on an even index.
	assign place_pair = idx[0] ? place1 : place0;
	assign mask_pair = idx[0] ? mask1 : mask0;
	// Pull clock pair starts on an odd index.
	assign pudclk_sel = idx[0] ? place0 : place1;

	// Sampled levels trimmed or extended to the pin count.
	always_comb begin
		levels_in64 = '0;
		levels_in64[gbc_pkg::FIELD_W-1:0] = exec.req.pin_levels;
	end
	assign now = levels_in64[NUM_PINS-1:0];

	// Next state of the vector registers.
	always_comb begin
		latch_d = latch_q;
		level_d = level_q;
		event_d = event_q;
		ren_d = ren_q;
		fen_d = fen_q;
		pud_d = pud_q;
		if (exec.fire) begin
			case (exec.req.command)
				gbc_pkg::CMD_WRITE: begin
					case (idx)
						gbc_pkg::REG_SET0, gbc_pkg::REG_SET1: begin
							latch_d = latch_q | place_pair;
						end
						gbc_pkg::REG_CLR0, gbc_pkg::REG_CLR1: begin
							latch_d = latch_q & ~place_pair;
						end
						gbc_pkg::REG_EDS0, gbc_pkg::REG_EDS1: begin
							event_d = event_q & ~place_pair;
						end
						gbc_pkg::REG_REN0, gbc_pkg::REG_REN1: begin
							ren_d = (ren_q & ~mask_pair) | place_pair;
						end
						gbc_pkg::REG_FEN0, gbc_pkg::REG_FEN1: begin
							fen_d = (fen_q & ~mask_pair) | place_pair;
						end
						gbc_pkg::REG_PUD: begin
							pud_d = wdata[1:0];
						end
						default: begin
						end
					endcase
				end
				gbc_pkg::CMD_TICK: begin
					event_d = event_q | (now & ~level_q & ren_q) | (~now & level_q & fen_q);
					level_d = now;
				end
				default: begin
				end
			endcase
		end
	end

	// Per-pin function select and pull mode.
	for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
		localparam int W = p / gbc_pkg::PINS_PER_FSEL;
		localparam int K = p % gbc_pkg::PINS_PER_FSEL;

		if (W < gbc_pkg::FSEL_WORDS) begin : g_fsel
			always_comb begin
				func_d[p] = func_q[p];
				if (is_write && (idx == 5'(W))) begin
					func_d[p] = wdata[gbc_pkg::FSEL_W*K +: gbc_pkg::FSEL_W];
				end
			end
		end else begin : g_nofsel
			assign func_d[p] = func_q[p];
		end

		always_comb begin
			pull_d[p] = pull_q[p];
			if (is_write && ((idx == gbc_pkg::REG_PUDCLK0) || (idx == gbc_pkg::REG_PUDCLK1))
					&& pudclk_sel[p]) begin
				pull_d[p] = pud_q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				func_q[p] <= '0;
				pull_q[p] <= gbc_pkg::PULL_OFF;
			end else begin
				func_q[p] <= func_d[p];
				pull_q[p] <= pull_d[p];
			end
		end

		assign oe_vec[p] = (func_d[p] == gbc_pkg::FSEL_OUTPUT);
		assign pu_vec[p] = (pull_d[p] == gbc_pkg::PULL_UP);
		assign pd_vec[p] = (pull_d[p] == gbc_pkg::PULL_DOWN);
	end

	// Vector registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			level_q <= '0;
			event_q <= '0;
			ren_q <= '0;
			fen_q <= '0;
			pud_q <= gbc_pkg::PULL_OFF;
		end else begin
			latch_q <= latch_d;
			level_q <= level_d;
			event_q <= event_d;
			ren_q <= ren_d;
			fen_q <= fen_d;
			pud_q <= pud_d;
		end
	end

	// Function select words as seen by a read; absent pins read as zero.
	for (genvar w = 0; w < gbc_pkg::FSEL_WORDS; w++) begin : g_fword
		for (genvar k = 0; k < gbc_pkg::PINS_PER_FSEL; k++) begin : g_fbit
			localparam int P = w * gbc_pkg::PINS_PER_FSEL + k;
			if (P < NUM_PINS) begin : g_on
				assign fsel_word[w][gbc_pkg::FSEL_W*k +: gbc_pkg::FSEL_W] = func_q[P];
			end else begin : g_off
				assign fsel_word[w][gbc_pkg::FSEL_W*k +: gbc_pkg::FSEL_W] = '0;
			end
		end
		assign fsel_word[w][gbc_pkg::DATA_W-1:gbc_pkg::FSEL_W*gbc_pkg::PINS_PER_FSEL] = '0;
	end

	// Current vectors widened to 64 bits so the high word reads zero above the pin count.
	always_comb begin
		level64 = '0;
		event64 = '0;
		ren64 = '0;
		fen64 = '0;
		level64[NUM_PINS-1:0] = level_q;
		event64[NUM_PINS-1:0] = event_q;
		ren64[NUM_PINS-1:0] = ren_q;
		fen64[NUM_PINS-1:0] = fen_q;
	end

	// Read multiplexer; zero for anything but a read.
	always_comb begin
		rd = '0;
		if (exec.req.command == gbc_pkg::CMD_READ) begin
			case (idx)
				gbc_pkg::REG_FSEL0, gbc_pkg::REG_FSEL1, gbc_pkg::REG_FSEL2,
				gbc_pkg::REG_FSEL3, gbc_pkg::REG_FSEL4, gbc_pkg::REG_FSEL5: begin
					rd = fsel_word[idx[2:0]];
				end
				gbc_pkg::REG_LEV0: rd = level64[31:0];
				gbc_pkg::REG_LEV1: rd = level64[63:32];
				gbc_pkg::REG_EDS0: rd = event64[31:0];
				gbc_pkg::REG_EDS1: rd = event64[63:32];
				gbc_pkg::REG_REN0: rd = ren64[31:0];
				gbc_pkg::REG_REN1: rd = ren64[63:32];
				gbc_pkg::REG_FEN0: rd = fen64[31:0];
				gbc_pkg::REG_FEN1: rd = fen64[63:32];
				gbc_pkg::REG_PUD: rd = {30'd0, pud_q};
				default: rd = '0;
			endcase
		end
	end

	// Pin views after this transaction's update, cut to the field width.
	always_comb begin
		latch64_d = '0;
		event64_d = '0;
		oe64 = '0;
		pu64 = '0;
		pd64 = '0;
		latch64_d[NUM_PINS-1:0] = latch_d;
		event64_d[NUM_PINS-1:0] = event_d;
		oe64[NUM_PINS-1:0] = oe_vec;
		pu64[NUM_PINS-1:0] = pu_vec;
		pd64[NUM_PINS-1:0] = pd_vec;
	end

	assign result.read_data = rd;
	assign result.drive_level = latch64_d[gbc_pkg::FIELD_W-1:0];
	assign result.output_enable = oe64[gbc_pkg::FIELD_W-1:0];
	assign result.pull_up_enable = pu64[gbc_pkg::FIELD_W-1:0];
	assign result.pull_down_enable = pd64[gbc_pkg::FIELD_W-1:0];
	assign result.event_interrupt = |event64_d[gbc_pkg::FIELD_W-1:0];

endmodule

// ===== sv/gpio_bank_controller_unit.sv =====
// GPIO bank controller top level: input register, register bank and response register.
// A transaction is accepted into the input register, executes in the register bank and is then
// captured in the response register; a stalled receiver holds the response there.
// Throughput: one transaction every cycle while the receiver takes each response.
// Reset: arst_n clears all pin state, the pull control and both stage valids at once.
// Depends on gbc_pkg and gbc_regs.
module gpio_bank_controller_unit #(
	parameter int NUM_PINS = gbc_pkg::NUM_PINS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input gbc_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output gbc_pkg::rsp_t rsp
);

	logic req_valid_s1;
	gbc_pkg::req_t req_s1;
	logic rsp_valid_s2;
	gbc_pkg::rsp_t rsp_s2;
	logic advance;
	gbc_pkg::exec_t exec;
	gbc_pkg::rsp_t result;

	// The held transaction executes when the response register is free or being emptied.
	assign advance = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	assign exec.fire = advance;
	assign exec.req = req_s1;

	gbc_regs #(
		.NUM_PINS(NUM_PINS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.exec(exec),
		.result(result)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp = rsp_s2;

	// An executed transaction always leaves a response behind.
	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("executed transaction left no response");

	// Only a read returns data.
	a_read_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_s1.command != gbc_pkg::CMD_READ) |=> (rsp.read_data == '0))
		else $error("read data nonzero for a non-read transaction");

	// Back-pressure on the request side only while a transaction is held.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> req_valid_s1 && rsp_valid_s2 && !rsp_ready)
		else $error("request stalled without a held transaction");

endmodule
